// File: rtl/upa_pkg.sv
// Shared types, register indexes and constants of the ultrasonic proximity alarm.
package upa_pkg;

   // Input item kinds carried in tuser
   typedef enum logic [1:0] {
      OP_REFRESH = 2'd0,
      OP_ECHO    = 2'd1,
      OP_BUTTON  = 2'd2
   } op_type;

   // Configuration register indexes
   localparam int CsrAddrWidth = 2;
   localparam int CsrDataWidth = 16;
   localparam logic [CsrAddrWidth-1:0] CSR_DEBOUNCE  = 2'd0;
   localparam logic [CsrAddrWidth-1:0] CSR_THR_STEP  = 2'd1;
   localparam logic [CsrAddrWidth-1:0] CSR_THR_MIN   = 2'd2;
   localparam logic [CsrAddrWidth-1:0] CSR_THR_MAX   = 2'd3;

   // Configuration reset values
   localparam logic [15:0] DEBOUNCE_RESET = 16'd150;
   localparam logic [7:0]  THR_STEP_RESET = 8'd5;
   localparam logic [7:0]  THR_MIN_RESET  = 8'd5;
   localparam logic [7:0]  THR_MAX_RESET  = 8'd200;

   // Payload widths
   localparam int PulseWidth = 21;
   localparam int DistWidth  = 10;
   localparam int ThrWidth   = 8;
   localparam int ReqDataWidth = 32;
   localparam int RspDataWidth = 32;

   // One input item, unpacked
   typedef struct packed {
      logic [1:0]            op;
      logic [PulseWidth-1:0] pulse_ticks;
      logic                  press_mode;
      logic                  press_up;
      logic                  press_down;
      logic                  press_buzz;
   } item_type;

   // Configuration register contents
   typedef struct packed {
      logic [15:0]         debounce_ticks;
      logic [ThrWidth-1:0] threshold_step;
      logic [ThrWidth-1:0] threshold_min;
      logic [ThrWidth-1:0] threshold_max;
   } cfg_type;

endpackage

// File: rtl/upa_csr.sv
// Configuration register file: debounce interval and threshold step and limits.
module upa_csr import upa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;

   // Write one register per enabled cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= DEBOUNCE_RESET;
         cfg_ff.threshold_step <= THR_STEP_RESET;
         cfg_ff.threshold_min  <= THR_MIN_RESET;
         cfg_ff.threshold_max  <= THR_MAX_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_DEBOUNCE: cfg_ff.debounce_ticks <= csr_wdata;
            CSR_THR_STEP: cfg_ff.threshold_step <= csr_wdata[ThrWidth-1:0];
            CSR_THR_MIN:  cfg_ff.threshold_min  <= csr_wdata[ThrWidth-1:0];
            CSR_THR_MAX:  cfg_ff.threshold_max  <= csr_wdata[ThrWidth-1:0];
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/upa_in_stage.sv
// Input register: unpacks and holds one request transaction for the core.
module upa_in_stage import upa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [ReqDataWidth-1:0] req_tdata,
   input  logic [1:0]              req_tuser,
   input  logic                    advance,
   output logic                    in_valid,
   output item_type                in_item
);

   logic     in_valid_ff;
   item_type item_ff;
   item_type item_in;
   logic     accept;

   // Take a new transaction when empty or when the held one moves on
   assign req_tready = !in_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   // Unpack the transaction fields
   always_comb begin
      item_in.op          = req_tuser;
      item_in.pulse_ticks = req_tdata[PulseWidth-1:0];
      item_in.press_mode  = req_tdata[PulseWidth];
      item_in.press_up    = req_tdata[PulseWidth+1];
      item_in.press_down  = req_tdata[PulseWidth+2];
      item_in.press_buzz  = req_tdata[PulseWidth+3];
   end

   // Valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign in_valid = in_valid_ff;
   assign in_item  = item_ff;

endmodule

// File: rtl/upa_core.sv
// Alarm core: one item per cycle unless stalled; the state registers form the result.
module upa_core import upa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   input  logic                    in_valid,
   input  item_type                in_item,
   output logic                    advance,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   localparam int EchoShift = 33;
   localparam logic [21:0] ECHO_RECIP = 22'd2962047;   // ceil(2^33 / 2900)
   localparam logic [9:0]  DIV3_RECIP = 10'd342;       // ceil(2^10 / 3)
   localparam logic [DistWidth-1:0] FAR_LIMIT = 10'd250;
   localparam logic [8:0]  PERIOD_FAR  = 9'd300;
   localparam logic [8:0]  PERIOD_MID  = 9'd160;
   localparam logic [8:0]  PERIOD_NEAR = 9'd80;
   localparam logic [8:0]  TONE_ON     = 9'd80;
   localparam logic [13:0] SHOW_MAX    = 14'd9999;
   localparam logic [ThrWidth-1:0] THR_RESET = 8'd20;

   localparam logic [6:0] SEG_TABLE [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   // floor(y / 3) for y below 512
   function automatic logic [ThrWidth-1:0] div3(input logic [8:0] y);
      logic [18:0] prod;
      prod = 19'(y) * 19'(DIV3_RECIP);
      return prod[17:10];
   endfunction

   // Decimal digit at position pos (0 = thousands) of v, v at most 9999
   function automatic logic [3:0] dec_digit(input logic [13:0] v, input logic [1:0] pos);
      logic [3:0]  d_th, d_hu, d_te;
      logic [13:0] r_th, r_hu, r_te;
      logic [3:0]  dig;
      d_th = 4'd0;
      r_th = v;
      for (int k = 1; k < 10; k++) begin
         if (v >= 14'(k * 1000)) begin
            d_th = 4'(k);
            r_th = v - 14'(k * 1000);
         end
      end
      d_hu = 4'd0;
      r_hu = r_th;
      for (int k = 1; k < 10; k++) begin
         if (r_th >= 14'(k * 100)) begin
            d_hu = 4'(k);
            r_hu = r_th - 14'(k * 100);
         end
      end
      d_te = 4'd0;
      r_te = r_hu;
      for (int k = 1; k < 10; k++) begin
         if (r_hu >= 14'(k * 10)) begin
            d_te = 4'(k);
            r_te = r_hu - 14'(k * 10);
         end
      end
      unique case (pos)
         2'd0: dig = d_th;
         2'd1: dig = d_hu;
         2'd2: dig = d_te;
         2'd3: dig = r_te[3:0];
      endcase
      return dig;
   endfunction

   logic                 out_valid_ff;
   logic [31:0]          tick_ff, tick_in;
   logic [31:0]          last_press_ff, last_press_in;
   logic [ThrWidth-1:0]  thr_ff, thr_in;
   logic                 mode_ff, mode_in;
   logic                 sound_ff, sound_in;
   logic [DistWidth-1:0] dist_ff, dist_in;
   logic [1:0]           scan_ff, scan_in;
   logic [8:0]           phase_ff, phase_in;
   logic                 tone_ff, tone_in;
   logic [6:0]           seg_ff, seg_in;
   logic [1:0]           digit_ff, digit_in;
   logic                 pin_ff, pin_in;

   logic [42:0]          echo_prod;
   logic [13:0]          show_val;
   logic [ThrWidth-1:0]  thr_two_thirds, thr_third;
   logic                 silent;
   logic [8:0]           period;
   logic [8:0]           phase_inc;
   logic                 any_press;
   logic [31:0]          elapsed;
   logic [ThrWidth:0]    thr_up_sum, thr_down_floor;
   logic [ThrWidth-1:0]  thr_after_up;

   // Move the held item into the state when the result slot frees up
   assign advance = in_valid && (!out_valid_ff || rsp_tready);

   // Echo distance by reciprocal multiply
   assign echo_prod = 43'(in_item.pulse_ticks) * 43'(ECHO_RECIP);

   // Displayed value and beep period from the current state
   always_comb begin
      show_val = mode_ff ? 14'(thr_ff) : 14'(dist_ff);
      if (show_val > SHOW_MAX) begin
         show_val = SHOW_MAX;
      end
      thr_two_thirds = div3({thr_ff, 1'b0});
      thr_third      = div3({1'b0, thr_ff});
      silent = !sound_ff || (dist_ff == '0) || (dist_ff > FAR_LIMIT)
               || (dist_ff > DistWidth'(thr_ff));
      priority if (silent) begin
         period = '0;
      end else if (dist_ff > DistWidth'(thr_two_thirds)) begin
         period = PERIOD_FAR;
      end else if (dist_ff > DistWidth'(thr_third)) begin
         period = PERIOD_MID;
      end else begin
         period = PERIOD_NEAR;
      end
      phase_inc = phase_ff + 9'd1;
   end

   // Button debounce and threshold arithmetic
   always_comb begin
      any_press = in_item.press_mode || in_item.press_up || in_item.press_down
                  || in_item.press_buzz;
      elapsed = tick_ff - last_press_ff;
      thr_up_sum = {1'b0, thr_ff} + {1'b0, cfg.threshold_step};
      thr_after_up = thr_ff;
      if (in_item.press_up) begin
         thr_after_up = (thr_up_sum <= {1'b0, cfg.threshold_max})
                        ? thr_up_sum[ThrWidth-1:0] : cfg.threshold_max;
      end
      thr_down_floor = {1'b0, cfg.threshold_min} + {1'b0, cfg.threshold_step};
   end

   // Next state for the held item
   always_comb begin
      tick_in       = tick_ff;
      last_press_in = last_press_ff;
      thr_in        = thr_ff;
      mode_in       = mode_ff;
      sound_in      = sound_ff;
      dist_in       = dist_ff;
      scan_in       = scan_ff;
      phase_in      = phase_ff;
      tone_in       = tone_ff;
      seg_in        = seg_ff;
      digit_in      = digit_ff;
      pin_in        = pin_ff;
      case (in_item.op)
         OP_REFRESH: begin
            tick_in  = tick_ff + 32'd1;
            digit_in = scan_ff;
            seg_in   = SEG_TABLE[dec_digit(show_val, scan_ff)];
            scan_in  = scan_ff + 2'd1;
            if (silent) begin
               pin_in   = 1'b0;
               phase_in = '0;
               tone_in  = 1'b0;
            end else begin
               phase_in = (phase_inc >= period) ? '0 : phase_inc;
               if (phase_in < TONE_ON) begin
                  tone_in = !tone_ff;
                  pin_in  = !tone_ff;
               end else begin
                  tone_in = 1'b0;
                  pin_in  = 1'b0;
               end
            end
         end
         OP_ECHO: begin
            dist_in = echo_prod[EchoShift +: DistWidth];
         end
         OP_BUTTON: begin
            if (any_press && (elapsed >= 32'(cfg.debounce_ticks))) begin
               last_press_in = tick_ff;
               sound_in = sound_ff ^ in_item.press_buzz;
               mode_in  = mode_ff ^ in_item.press_mode;
               if (mode_in) begin
                  thr_in = thr_after_up;
                  if (in_item.press_down) begin
                     thr_in = ({1'b0, thr_after_up} >= thr_down_floor)
                              ? thr_after_up - cfg.threshold_step : cfg.threshold_min;
                  end
               end
            end
         end
         default: begin
            // undefined kind: hold state, report current outputs
         end
      endcase
   end

   // Result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // State registers, also the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff       <= '0;
         last_press_ff <= '0;
         thr_ff        <= THR_RESET;
         mode_ff       <= 1'b0;
         sound_ff      <= 1'b1;
         dist_ff       <= '0;
         scan_ff       <= '0;
         phase_ff      <= '0;
         tone_ff       <= 1'b0;
         seg_ff        <= '0;
         digit_ff      <= '0;
         pin_ff        <= 1'b0;
      end else if (advance) begin
         tick_ff       <= tick_in;
         last_press_ff <= last_press_in;
         thr_ff        <= thr_in;
         mode_ff       <= mode_in;
         sound_ff      <= sound_in;
         dist_ff       <= dist_in;
         scan_ff       <= scan_in;
         phase_ff      <= phase_in;
         tone_ff       <= tone_in;
         seg_ff        <= seg_in;
         digit_ff      <= digit_in;
         pin_ff        <= pin_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, sound_ff, mode_ff, thr_ff, dist_ff, pin_ff, seg_ff, digit_ff};

endmodule

// File: rtl/ultrasonic_proximity_alarm.sv
// Ultrasonic proximity alarm: parking sensor display scan, buzzer tone and buttons.
//
// Request channel (req_*): one transaction per event. tuser selects the kind:
// refresh tick, echo measured or button event. tdata carries the echo width
// and the four button flags. Each request yields exactly one response.
// Response channel (rsp_*): the lit digit and its segments, the buzzer pin,
// distance, threshold, setup mode and buzzer enable after the event.
// Configuration (csr_*): register writes take effect on the next edge; write
// only while no request is in flight.
// Path: request acceptance into the input register, then into the state/result
// register, which drives the response. Throughput: one transaction per cycle
// while rsp_tready is high; the event logic between the two registers is
// combinational, with the echo distance taken by one reciprocal multiply.
// Reset: synchronous, active high; clears both stages and loads the reset
// state (threshold 20, normal mode, buzzer enabled, distance 0).
// Stall: when rsp_tready is low the response holds, one more request waits
// in the input register, and req_tready then drops until the response moves.
module ultrasonic_proximity_alarm import upa_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [20:0] pulse_ticks, [21] press_mode, [22] press_up, [23] press_down,
   // [24] press_buzz, [31:25] zero
   input  logic [ReqDataWidth-1:0] req_tdata,
   // [1:0] op
   input  logic [1:0]              req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [1:0] digit_select, [8:2] segments, [9] buzzer_level, [19:10] distance_cm,
   // [27:20] threshold_cm, [28] setup_mode, [29] alarm_enabled, [31:30] zero
   output logic [RspDataWidth-1:0] rsp_tdata,
   input  logic                    csr_we,
   input  logic [CsrAddrWidth-1:0] csr_addr,
   input  logic [CsrDataWidth-1:0] csr_wdata
);

   cfg_type  cfg;
   item_type in_item;
   logic     in_valid;
   logic     advance;

   upa_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   upa_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_item    (in_item)
   );

   upa_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (in_valid),
      .in_item    (in_item),
      .advance    (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A transaction moved into the core always shows up as a response
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced transaction produced no response");

   // A held request is never dropped while the response is stalled
   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      in_valid && rsp_tvalid && !rsp_tready |=> in_valid)
      else $error("held request lost during response stall");

   // Both stages full and stalled: no new request may be taken
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while both stages are full");

endmodule
